// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the compressor RTL.
// Depends on nothing; the including module supplies clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge outside reset
`define CHECK_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("invariant violated");

// implication checked in the same cycle
`define CHECK_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication violated");

// implication checked in the next cycle
`define CHECK_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

// ===== hdl/lzwc_pkg.sv =====
// Package for the LZW compressor: beat payload types, dictionary control struct
// and the fixed code values. No dependencies.
`timescale 1ns / 1ps

package lzwc_pkg;

   localparam int CODE_CLEAR = 256;
   localparam int CODE_END   = 257;
   localparam int CODE_FIRST = 258;
   localparam int START_BITS = 9;
   localparam int MAX_OUT    = 8;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       stream_end;
   } rsp_payload_type;

   typedef struct packed {
      logic head_rd;
      logic head_wr;
      logic ent_rd;
      logic ent_wr;
   } dict_ctl_type;

endpackage

// ===== hdl/lzwc_dict.sv =====
// Dictionary storage: per-code head-of-children table and per-code entry table
// (parent, symbol, next sibling). Uses lzwc_pkg.
`timescale 1ns / 1ps

module lzwc_dict
   import lzwc_pkg::*;
#(
   parameter int AW = 12
) (
   input  logic          clock,
   input  dict_ctl_type  ctl,
   input  logic [AW-1:0] head_raddr,
   input  logic [AW-1:0] head_waddr,
   input  logic [AW-1:0] head_wdata,
   output logic [AW-1:0] head_rdata,
   input  logic [AW-1:0] ent_raddr,
   input  logic [AW-1:0] ent_waddr,
   input  logic [AW-1:0] ent_wparent,
   input  logic [7:0]    ent_wsym,
   input  logic [AW-1:0] ent_wsib,
   output logic [AW-1:0] ent_rparent,
   output logic [7:0]    ent_rsym,
   output logic [AW-1:0] ent_rsib
);

   localparam int DEPTH = 1 << AW;
   localparam int EW    = 2 * AW + 8;

   logic [AW-1:0] head_mem [DEPTH];
   logic [EW-1:0] ent_mem  [DEPTH];
   logic [EW-1:0] ent_q_ff;

   always_ff @(posedge clock) begin
      if (ctl.head_wr) begin
         head_mem[head_waddr] <= head_wdata;
      end
      if (ctl.head_rd) begin
         head_rdata <= head_mem[head_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ent_wr) begin
         ent_mem[ent_waddr] <= {ent_wparent, ent_wsym, ent_wsib};
      end
      if (ctl.ent_rd) begin
         ent_q_ff <= ent_mem[ent_raddr];
      end
   end

   assign ent_rparent = ent_q_ff[EW-1 -: AW];
   assign ent_rsym    = ent_q_ff[AW +: 8];
   assign ent_rsib    = ent_q_ff[AW-1:0];

endmodule

// ===== hdl/lzw_variable_width_compressor.sv =====
// LZW compressor top level: handshake ports, code sequencer, bit packer.
// Uses lzwc_pkg, lzwc_dict and assert_macros.svh.
`timescale 1ns / 1ps
// After reset the block clears its child-head table and stalls req_ meanwhile;
// csr_ writes are taken at any time. An input byte is then matched by walking
// the children of the current prefix in the dictionary memory: the head read,
// then one entry read per sibling visited, then closing the item. A miss sends
// the prefix code through the packer and inserts the new entry; the first byte
// of a stream adds the four-byte length header. Output bytes leave through a
// register and are stalled only by rsp_stall.

module lzw_variable_width_compressor
   import lzwc_pkg::*;
#(
   parameter int DICT_ENTRIES  = 4096,
   parameter int MAX_CODE_BITS = 12
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [31:0]     csr_wdata
);

`include "assert_macros.svh"

   localparam int AW   = $clog2(DICT_ENTRIES);
   localparam int NW   = $clog2(DICT_ENTRIES + 1);
   localparam int MW   = MAX_CODE_BITS;
   localparam int CBW  = $clog2(MAX_CODE_BITS + 1);
   localparam int ACCW = MW + 7;
   localparam int CNTW = $clog2(ACCW + 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_HDR, S_HEAD_CHK, S_ENT_CHK, S_MISS, S_NEWENT,
      S_LASTCHK, S_ENDCODE, S_PUT, S_DRAIN, S_PAD, S_FINISH
   } state_type;

   state_type       state_ff, state_in, ret_ff, ret_in;
   logic [31:0]     stream_length_ff, stream_length_in;
   logic [NW-1:0]   next_free_ff, next_free_in;
   logic [CBW-1:0]  code_width_ff, code_width_in;
   logic [AW-1:0]   prefix_ff, prefix_in;
   logic            started_ff, started_in;
   logic [ACCW-1:0] acc_ff, acc_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [7:0]      sym_ff, sym_in;
   logic            last_ff, last_in;
   logic [3:0]      nout_ff, nout_in;
   logic [1:0]      idx_ff, idx_in;
   logic [AW-1:0]   cand_ff, cand_in;
   logic [AW-1:0]   sib_ff, sib_in;
   logic            first_ff, first_in;
   logic [AW-1:0]   put_code_ff, put_code_in;
   logic [CBW-1:0]  put_w_ff, put_w_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic            hold_valid_ff, hold_valid_in;
   logic [7:0]      hold_byte_ff, hold_byte_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   dict_ctl_type    ctl;
   logic [AW-1:0]   head_raddr, head_waddr, head_wdata, head_rdata;
   logic [AW-1:0]   ent_raddr, ent_waddr, ent_rparent, ent_rsib;
   logic [7:0]      ent_rsym;

   logic            out_free, can_prod, want, step_ok, prod_go;
   logic [7:0]      prod_byte;
   logic [MW-1:0]   masked;
   logic [NW-1:0]   nf_inc;

   lzwc_dict #(.AW(AW)) u_dict (
      .clock       (clock),
      .ctl         (ctl),
      .head_raddr  (head_raddr),
      .head_waddr  (head_waddr),
      .head_wdata  (head_wdata),
      .head_rdata  (head_rdata),
      .ent_raddr   (ent_raddr),
      .ent_waddr   (ent_waddr),
      .ent_wparent (prefix_ff),
      .ent_wsym    (sym_ff),
      .ent_wsib    (sib_ff),
      .ent_rparent (ent_rparent),
      .ent_rsym    (ent_rsym),
      .ent_rsib    (ent_rsib)
   );

   assign csr_ready   = 1'b1;
   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign can_prod = !hold_valid_ff || out_free;
   assign want     = (nout_ff < 4'(MAX_OUT));
   assign step_ok  = !want || can_prod;
   assign nf_inc   = next_free_ff + NW'(1);

   always_comb begin
      for (int i = 0; i < MW; i++) begin
         masked[i] = (i < AW) ? (put_code_ff[i % AW] && (i < int'(put_w_ff))) : 1'b0;
      end
   end

   always_comb begin
      state_in         = state_ff;
      ret_in           = ret_ff;
      stream_length_in = csr_valid ? csr_wdata : stream_length_ff;
      next_free_in     = next_free_ff;
      code_width_in    = code_width_ff;
      prefix_in        = prefix_ff;
      started_in       = started_ff;
      acc_in           = acc_ff;
      cnt_in           = cnt_ff;
      sym_in           = sym_ff;
      last_in          = last_ff;
      nout_in          = nout_ff;
      idx_in           = idx_ff;
      cand_in          = cand_ff;
      sib_in           = sib_ff;
      first_in         = first_ff;
      put_code_in      = put_code_ff;
      put_w_in         = put_w_ff;
      clr_in           = clr_ff;
      hold_valid_in    = hold_valid_ff;
      hold_byte_in     = hold_byte_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_payload_in   = rsp_payload_ff;
      ctl              = '0;
      head_raddr       = prefix_ff;
      head_waddr       = prefix_ff;
      head_wdata       = AW'(next_free_ff);
      ent_raddr        = cand_ff;
      ent_waddr        = AW'(next_free_ff);
      prod_go          = 1'b0;
      prod_byte        = '0;

      case (state_ff)
         S_CLEAR: begin
            ctl.head_wr = 1'b1;
            head_waddr  = clr_ff;
            head_wdata  = '0;
            clr_in      = clr_ff + AW'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               sym_in  = req_payload.data_byte;
               last_in = req_payload.last_byte;
               nout_in = '0;
               idx_in  = '0;
               if (!started_ff) begin
                  state_in = S_HDR;
               end else begin
                  ctl.head_rd = 1'b1;
                  state_in    = S_HEAD_CHK;
               end
            end
         end
         S_HDR: begin
            if (can_prod) begin
               prod_go = 1'b1;
               case (idx_ff)
                  2'd0:    prod_byte = stream_length_ff[31:24];
                  2'd1:    prod_byte = stream_length_ff[23:16];
                  2'd2:    prod_byte = stream_length_ff[15:8];
                  default: prod_byte = stream_length_ff[7:0];
               endcase
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  put_code_in = AW'(CODE_CLEAR);
                  put_w_in    = code_width_ff;
                  ret_in      = S_LASTCHK;
                  started_in  = 1'b1;
                  prefix_in   = AW'(sym_ff);
                  state_in    = S_PUT;
               end
            end
         end
         S_HEAD_CHK: begin
            first_in = 1'b1;
            cand_in  = head_rdata;
            if (head_rdata >= AW'(CODE_FIRST) && NW'(head_rdata) < next_free_ff) begin
               sib_in     = head_rdata;
               ctl.ent_rd = 1'b1;
               ent_raddr  = head_rdata;
               state_in   = S_ENT_CHK;
            end else begin
               sib_in   = '0;
               state_in = S_MISS;
            end
         end
         S_ENT_CHK: begin
            first_in = 1'b0;
            if (first_ff && ent_rparent != prefix_ff) begin
               sib_in   = '0;
               state_in = S_MISS;
            end else if (ent_rsym == sym_ff) begin
               prefix_in = cand_ff;
               state_in  = S_LASTCHK;
            end else if (ent_rsib != '0) begin
               cand_in    = ent_rsib;
               ctl.ent_rd = 1'b1;
               ent_raddr  = ent_rsib;
            end else begin
               state_in = S_MISS;
            end
         end
         S_MISS: begin
            put_code_in = prefix_ff;
            put_w_in    = code_width_ff;
            ret_in      = S_NEWENT;
            state_in    = S_PUT;
         end
         S_NEWENT: begin
            prefix_in = AW'(sym_ff);
            if (next_free_ff < NW'(DICT_ENTRIES)) begin
               ctl.ent_wr   = 1'b1;
               ctl.head_wr  = 1'b1;
               next_free_in = nf_inc;
               if ((nf_inc >> code_width_ff) != '0 && code_width_ff < CBW'(MW)) begin
                  code_width_in = code_width_ff + CBW'(1);
               end
               state_in = S_LASTCHK;
            end else begin
               put_code_in   = AW'(CODE_CLEAR);
               put_w_in      = code_width_ff;
               next_free_in  = NW'(CODE_FIRST);
               code_width_in = CBW'(START_BITS);
               ret_in        = S_LASTCHK;
               state_in      = S_PUT;
            end
         end
         S_LASTCHK: begin
            if (last_ff) begin
               put_code_in = prefix_ff;
               put_w_in    = code_width_ff;
               ret_in      = S_ENDCODE;
               state_in    = S_PUT;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_ENDCODE: begin
            put_code_in = AW'(CODE_END);
            put_w_in    = code_width_ff;
            ret_in      = S_PAD;
            state_in    = S_PUT;
         end
         S_PUT: begin
            acc_in   = (ACCW'(acc_ff[6:0]) << put_w_ff) | ACCW'(masked);
            cnt_in   = cnt_ff + CNTW'(put_w_ff);
            state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (cnt_ff >= CNTW'(8)) begin
               if (step_ok) begin
                  prod_go   = want;
                  prod_byte = 8'(acc_ff >> (cnt_ff - CNTW'(8)));
                  cnt_in    = cnt_ff - CNTW'(8);
               end
            end else begin
               state_in = ret_ff;
            end
         end
         S_PAD: begin
            if (cnt_ff == '0 || step_ok) begin
               prod_go       = want && (cnt_ff != '0);
               prod_byte     = 8'({1'b0, acc_ff[6:0]} << (CNTW'(8) - cnt_ff));
               cnt_in        = '0;
               acc_in        = '0;
               next_free_in  = NW'(CODE_FIRST);
               code_width_in = CBW'(START_BITS);
               prefix_in     = '0;
               started_in    = 1'b0;
               state_in      = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!hold_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = '{out_byte: hold_byte_ff, run_last: 1'b1,
                                  stream_end: last_ff};
               hold_valid_in  = 1'b0;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (prod_go) begin
         nout_in       = nout_ff + 4'd1;
         hold_valid_in = 1'b1;
         hold_byte_in  = prod_byte;
         if (hold_valid_ff) begin
            rsp_valid_in   = 1'b1;
            rsp_payload_in = '{out_byte: hold_byte_ff, run_last: 1'b0, stream_end: 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_CLEAR;
         ret_ff           <= S_IDLE;
         stream_length_ff <= 32'd1;
         next_free_ff     <= NW'(CODE_FIRST);
         code_width_ff    <= CBW'(START_BITS);
         prefix_ff        <= '0;
         started_ff       <= 1'b0;
         acc_ff           <= '0;
         cnt_ff           <= '0;
         nout_ff          <= '0;
         idx_ff           <= '0;
         first_ff         <= 1'b0;
         clr_ff           <= '0;
         hold_valid_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         ret_ff           <= ret_in;
         stream_length_ff <= stream_length_in;
         next_free_ff     <= next_free_in;
         code_width_ff    <= code_width_in;
         prefix_ff        <= prefix_in;
         started_ff       <= started_in;
         acc_ff           <= acc_in;
         cnt_ff           <= cnt_in;
         nout_ff          <= nout_in;
         idx_ff           <= idx_in;
         first_ff         <= first_in;
         clr_ff           <= clr_in;
         hold_valid_ff    <= hold_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      sym_ff         <= sym_in;
      last_ff        <= last_in;
      cand_ff        <= cand_in;
      sib_ff         <= sib_in;
      put_code_ff    <= put_code_in;
      put_w_ff       <= put_w_in;
      hold_byte_ff   <= hold_byte_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   `CHECK_ALWAYS(a_free_range, next_free_ff >= NW'(CODE_FIRST) && next_free_ff <= NW'(DICT_ENTRIES))
   `CHECK_IMPLY(a_idle_clean, state_ff == S_IDLE, !hold_valid_ff && cnt_ff < CNTW'(8))
   `CHECK_NEXT(a_last_closes, state_ff == S_PAD && state_in == S_FINISH, !started_ff && cnt_ff == '0)

endmodule
